// ----- rtl/mspet_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mspet_pkg
// Shared types and constants of the multi-slot periodic event timer: slot
// count, slot table entry layout, request, result kind and status codes.
// ----------------------------------------------------------------------------
package mspet_pkg;

  localparam int unsigned SLOTS = 10;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_POLL  = 2'd3
  } req_e;

  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  localparam logic [1:0] ST_EXISTING  = 2'd0;
  localparam logic [1:0] ST_NEW_SLOT  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [7:0]  owner;
    logic        assigned;
    logic [23:0] period;
    logic [23:0] remaining;
    logic [15:0] repeats;
  } slot_t;

endpackage
`default_nettype wire

// ----- rtl/multi_slot_periodic_event_timer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_periodic_event_timer
// Table of periodic event slots kept in one synchronous memory. Each request
// scans the table slot by slot, a tick or poll with a read-modify-write per slot.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in channel (valid/ready): tick, start, stop or poll.
//   Results leave on the out channel (valid/ready), one per fired task or one
//   acknowledgement per start or stop, with last_o set on the final result of
//   each request. A tick or poll where nothing fires gives no result.
//   One request is worked on at a time, one memory read per scan cycle unless
//   the scan is halted, with the updated slot of a tick or poll written back
//   as the next slot is read. The next request is taken once the last result
//   is loaded into the output register; a silent tick or poll frees the input
//   once its scan ends. Receiver stalls can delay both.
//   The out channel has an output register and a one-result pending stage:
//   a stalled receiver halts the scan only when a second fire must be queued.
//   in_ready_o is high whenever no request is in progress, even while a
//   result still waits to be taken.
//   After reset every slot reads as empty (zero owner, idle, zero times);
//   per-slot valid bits stand in for clearing the memory.
// ----------------------------------------------------------------------------
module multi_slot_periodic_event_timer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [7:0]         task_id_i,
  input  wire logic [23:0]        period_ticks_i,
  input  wire logic signed [15:0] repeat_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    kind_o,
  output logic [7:0]              fired_id_o,
  output logic [1:0]              status_o,
  output logic                    last_o
);

  localparam int unsigned IW = mspet_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // slot memory, read data registered
  mspet_pkg::slot_t slot_mem_q [mspet_pkg::SLOTS];
  logic [mspet_pkg::SLOTS-1:0] slot_vld_q;
  mspet_pkg::slot_t rd_q;
  logic             rd_vld_q;
  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_wa, mem_ra;
  mspet_pkg::slot_t mem_wd;

  // request registers
  mspet_pkg::req_e req_q;
  logic [7:0]      id_q;
  logic [23:0]     per_q;
  logic [15:0]     rep_q;
  logic [IW-1:0]   eval_idx_q;

  // scan results for start and stop
  logic             found_q, idle_found_q;
  logic [IW-1:0]    found_idx_q, idle_idx_q;
  mspet_pkg::slot_t found_ent_q;

  // fire waiting for its last marker
  logic       pend_vld_q;
  logic [7:0] pend_id_q;

  // output register
  logic       out_valid_q;
  logic       out_kind_q, out_last_q;
  logic [7:0] out_id_q;
  logic [1:0] out_status_q;

  logic             out_load, out_kind_d, out_last_d;
  logic [7:0]       out_id_d;
  logic [1:0]       out_status_d;
  logic             pend_vld_d;

  mspet_pkg::slot_t ent, upd;
  logic             is_tp, fire, adv, out_free, last_slot, id_match, accept;
  logic [23:0]      rem_dec;
  logic [15:0]      rep_new;

  assign ent       = rd_vld_q ? rd_q : '0;
  assign out_free  = !out_valid_q || out_ready_i;
  assign is_tp     = (req_q == mspet_pkg::REQ_TICK) || (req_q == mspet_pkg::REQ_POLL);
  assign last_slot = (eval_idx_q == IW'(mspet_pkg::SLOTS - 1));
  assign id_match  = ent.assigned && (ent.owner == id_q);
  assign rem_dec   = ent.remaining - 24'd1;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept    = in_valid_i && in_ready_o;

  // per-slot countdown and fire update
  always_comb begin
    upd  = ent;
    fire = 1'b0;
    if (req_q == mspet_pkg::REQ_TICK) begin
      if (ent.repeats != 16'd0 && ent.remaining != 24'd0) begin
        upd.remaining = rem_dec;
        fire          = (rem_dec == 24'd0);
      end
    end else begin
      fire = (ent.remaining == 24'd0) && (ent.repeats != 16'd0);
    end
    // positive counts count down, negative ones repeat forever
    rep_new = (ent.repeats != 16'd0 && !ent.repeats[15]) ? ent.repeats - 16'd1
                                                          : ent.repeats;
    if (fire) begin
      upd.repeats = rep_new;
      if (rep_new != 16'd0) begin
        upd.remaining = ent.period;
      end
    end
  end

  // a second fire can only be queued when the output register frees up
  assign adv = !(is_tp && fire && pend_vld_q && !out_free);

  always_comb begin
    state_d      = state_q;
    mem_we       = 1'b0;
    mem_wa       = eval_idx_q;
    mem_wd       = upd;
    mem_re       = 1'b0;
    mem_ra       = '0;
    out_load     = 1'b0;
    out_kind_d   = mspet_pkg::KIND_FIRE;
    out_id_d     = pend_id_q;
    out_status_d = mspet_pkg::ST_EXISTING;
    out_last_d   = 1'b0;
    pend_vld_d   = pend_vld_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mem_re  = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (adv) begin
          if (is_tp) begin
            mem_we = 1'b1;
            if (fire) begin
              pend_vld_d = 1'b1;
              out_load   = pend_vld_q;
            end
          end
          if (!last_slot) begin
            mem_re = 1'b1;
            mem_ra = eval_idx_q + IW'(1);
          end else if (is_tp) begin
            state_d = (pend_vld_q || fire) ? S_FLUSH : S_IDLE;
          end else begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = mspet_pkg::KIND_ACK;
          out_id_d   = id_q;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
          if (req_q == mspet_pkg::REQ_START) begin
            mem_wd.owner     = id_q;
            mem_wd.assigned  = 1'b1;
            mem_wd.period    = per_q;
            mem_wd.remaining = per_q;
            mem_wd.repeats   = rep_q;
            if (found_q) begin
              mem_we       = 1'b1;
              mem_wa       = found_idx_q;
              out_status_d = mspet_pkg::ST_EXISTING;
            end else if (idle_found_q) begin
              mem_we       = 1'b1;
              mem_wa       = idle_idx_q;
              out_status_d = mspet_pkg::ST_NEW_SLOT;
            end else begin
              out_status_d = mspet_pkg::ST_FULL;
            end
          end else begin
            mem_wd         = found_ent_q;
            mem_wd.repeats = 16'd0;
            mem_wa         = found_idx_q;
            mem_we         = found_q;
            out_status_d   = found_q ? mspet_pkg::ST_EXISTING : mspet_pkg::ST_NOT_FOUND;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= slot_mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (mem_we) begin
        slot_vld_q[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= slot_vld_q[mem_ra];
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      eval_idx_q   <= '0;
      pend_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      idle_found_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        eval_idx_q   <= '0;
        found_q      <= 1'b0;
        idle_found_q <= 1'b0;
      end else if (state_q == S_SCAN && adv) begin
        eval_idx_q <= eval_idx_q + IW'(1);
        if (!is_tp && !found_q) begin
          if (id_match) begin
            found_q <= 1'b1;
          end else if (!idle_found_q && ent.repeats == 16'd0) begin
            idle_found_q <= 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= mspet_pkg::req_e'(req_type_i);
      id_q  <= task_id_i;
      per_q <= period_ticks_i;
      rep_q <= $unsigned(repeat_count_i);
    end
    if (state_q == S_SCAN && adv) begin
      if (is_tp && fire) begin
        pend_id_q <= ent.owner;
      end
      if (!is_tp && !found_q) begin
        if (id_match) begin
          found_idx_q <= eval_idx_q;
          found_ent_q <= ent;
        end else if (!idle_found_q && ent.repeats == 16'd0) begin
          idle_idx_q <= eval_idx_q;
        end
      end
    end
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_id_q     <= out_id_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign fired_id_o  = out_id_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule
`default_nettype wire
